>>> hw/rtl/phdf_pkg.sv
// Package for the packet hook dispatch filter: sizes, result and register codes,
// the hook entry type and the microcode ROM of the sequencer.
// No dependencies.
`default_nettype none

package phdf_pkg;

    // Table and result sizing.
    localparam int HOOK_SLOTS  = 8;
    localparam int BUS_COUNT   = 4;
    localparam int MAX_RESULTS = 10;
    localparam int SLOT_W      = (HOOK_SLOTS > 1) ? $clog2(HOOK_SLOTS) : 1;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    // Field widths fixed by the interface.
    localparam int NODE_W  = 11;
    localparam int TYPE_W  = 8;
    localparam int ADDR_W  = 16;
    localparam int PORT_W  = 8;
    localparam int DLEN_W  = 4;
    localparam int BYTE_W  = 8;
    localparam int BUS_W   = 2;
    localparam int KIND_W  = 3;
    localparam int INDEX_W = 3;
    localparam int CFG_W   = 11;
    localparam int CFGI_W  = 2;

    // Wildcard codes in a stored hook.
    localparam logic [TYPE_W-1:0] TYPE_ANY   = 8'hFF;
    localparam logic [ADDR_W-1:0] TARGET_ANY = 16'h0000;
    localparam logic [PORT_W-1:0] PORT_ANY   = 8'hFF;
    localparam logic [BYTE_W-1:0] BYTE_ANY   = 8'hFF;

    // Input function codes.
    localparam logic FUNC_ATTACH = 1'b0;
    localparam logic FUNC_PACKET = 1'b1;

    // Result kinds.
    localparam logic [KIND_W-1:0] KIND_ATTACH_OK = 3'd0;
    localparam logic [KIND_W-1:0] KIND_FULL      = 3'd1;
    localparam logic [KIND_W-1:0] KIND_MATCH     = 3'd2;
    localparam logic [KIND_W-1:0] KIND_PONG      = 3'd3;
    localparam logic [KIND_W-1:0] KIND_DONE      = 3'd4;

    // Configuration register indexes.
    localparam logic [CFGI_W-1:0] CFG_NODE_ID      = 2'd0;
    localparam logic [CFGI_W-1:0] CFG_PING_COMMAND = 2'd1;
    localparam logic [CFGI_W-1:0] CFG_UNICAST_TYPE = 2'd2;

    // Microprogram step addresses.
    localparam int STEP_W = 3;
    localparam logic [STEP_W-1:0] STEP_IDLE   = 3'd0;
    localparam logic [STEP_W-1:0] STEP_PING   = 3'd1;
    localparam logic [STEP_W-1:0] STEP_SCAN   = 3'd2;
    localparam logic [STEP_W-1:0] STEP_DONE   = 3'd3;
    localparam logic [STEP_W-1:0] STEP_ATTACH = 3'd4;

    typedef struct packed {
        logic [TYPE_W-1:0] htype;
        logic [ADDR_W-1:0] target;
        logic [PORT_W-1:0] port;
        logic [BYTE_W-1:0] first_byte;
    } hook_t;

    // Next-address selection of a control word.
    typedef enum logic [1:0] {
        SEQ_NEXT = 2'd0,  // fall through
        SEQ_JUMP = 2'd1,  // unconditional jump
        SEQ_FUNC = 2'd2,  // jump when the incoming word is an attach
        SEQ_LOOP = 2'd3   // repeat until the last slot has been scanned
    } seq_t;

    // Condition under which a step emits a result.
    typedef enum logic [1:0] {
        COND_NONE   = 2'd0,
        COND_ALWAYS = 2'd1,
        COND_PING   = 2'd2,
        COND_MATCH  = 2'd3
    } cond_t;

    typedef struct packed {
        logic              wait_in;
        cond_t             cond;
        logic [KIND_W-1:0] kind;
        logic              last;
        logic              attach;
        logic              scan_clr;
        seq_t              seq;
        logic [STEP_W-1:0] jump;
    } ucw_t;

    function automatic ucw_t ucode_rom(input logic [STEP_W-1:0] step);
        ucw_t w;
        w = '{wait_in: 1'b0, cond: COND_NONE, kind: KIND_DONE, last: 1'b0,
              attach: 1'b0, scan_clr: 1'b0, seq: SEQ_JUMP, jump: STEP_IDLE};
        case (step)
            STEP_IDLE:
            begin
                w.wait_in = 1'b1;
                w.seq     = SEQ_FUNC;
                w.jump    = STEP_ATTACH;
            end
            STEP_PING:
            begin
                w.cond     = COND_PING;
                w.kind     = KIND_PONG;
                w.scan_clr = 1'b1;
                w.seq      = SEQ_NEXT;
            end
            STEP_SCAN:
            begin
                w.cond = COND_MATCH;
                w.kind = KIND_MATCH;
                w.seq  = SEQ_LOOP;
            end
            STEP_DONE:
            begin
                w.cond = COND_ALWAYS;
                w.kind = KIND_DONE;
                w.last = 1'b1;
            end
            STEP_ATTACH:
            begin
                w.cond   = COND_ALWAYS;
                w.attach = 1'b1;
                w.last   = 1'b1;
            end
            default:
            begin
                w.seq  = SEQ_JUMP;
                w.jump = STEP_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/packet_hook_dispatch_filter.sv
// Top level of the packet hook dispatch filter: hook table, microcoded
// sequencer and output register. Depends on phdf_pkg.
`default_nettype none

// The block holds a table of eight packet hooks, each a type, a target, a port
// and a first payload byte, any of which may be a wildcard. An attach word
// stores a hook in the lowest free slot and returns one result: the slot, or
// "table full". A packet word returns a pong result first when it is a unicast
// ping for this node, then one match result per matching hook in slot order,
// and finally a done result with last set. A small microprogram sequences the
// work: one step takes the input word, one step checks for a ping, one step
// per hook slot scans the table (a single comparator shared by all slots),
// and one step gives the done result; an attach word goes on from the input
// step to the attach step. A stalled output holds the sequencer on its next
// result step. The output register lets the next input word be taken while the
// last result of the previous word still waits. Configuration must be written
// through cfg_we, cfg_index and cfg_data only while the block is idle; the
// block itself does not enforce this.
module packet_hook_dispatch_filter (
    input  wire                                  clk,
    input  wire                                  rst_n,
    // configuration
    input  wire                                  cfg_we,
    input  wire  [phdf_pkg::CFGI_W-1:0]          cfg_index,
    input  wire  [phdf_pkg::CFG_W-1:0]           cfg_data,
    // input words
    input  wire                                  in_valid,
    output logic                                 in_stall,
    input  wire                                  func,
    input  wire  [phdf_pkg::TYPE_W-1:0]          pkt_type,
    input  wire  [phdf_pkg::ADDR_W-1:0]          target,
    input  wire  [phdf_pkg::ADDR_W-1:0]          source,
    input  wire  signed [phdf_pkg::PORT_W-1:0]   port,
    input  wire  [phdf_pkg::DLEN_W-1:0]          data_length,
    input  wire  [phdf_pkg::BYTE_W-1:0]          first_byte,
    input  wire  [phdf_pkg::BUS_W-1:0]           bus_index,
    // result words
    output logic                                 out_valid,
    input  wire                                  out_stall,
    output logic [phdf_pkg::KIND_W-1:0]          kind,
    output logic [phdf_pkg::INDEX_W-1:0]         hook_index,
    output logic [phdf_pkg::ADDR_W-1:0]          reply_target,
    output logic signed [phdf_pkg::PORT_W-1:0]   reply_port,
    output logic [phdf_pkg::BUS_W-1:0]           reply_bus,
    output logic                                 last
);

    // Configuration registers.
    logic [phdf_pkg::NODE_W-1:0] node_id_reg;
    logic [phdf_pkg::BYTE_W-1:0] ping_cmd_reg;
    logic [phdf_pkg::TYPE_W-1:0] ucast_type_reg;

    // Hook table: valid bits are reset, entries are written before use.
    logic [phdf_pkg::HOOK_SLOTS-1:0] hook_valid_reg;
    phdf_pkg::hook_t                 hook_reg [phdf_pkg::HOOK_SLOTS];

    // Latched input word.
    logic [phdf_pkg::TYPE_W-1:0] type_reg;
    logic [phdf_pkg::ADDR_W-1:0] target_reg;
    logic [phdf_pkg::ADDR_W-1:0] source_reg;
    logic [phdf_pkg::PORT_W-1:0] port_reg;
    logic [phdf_pkg::DLEN_W-1:0] dlen_reg;
    logic [phdf_pkg::BYTE_W-1:0] fbyte_reg;
    logic [phdf_pkg::BUS_W-1:0]  bus_reg;

    // Sequencer state.
    logic [phdf_pkg::STEP_W-1:0] pc_reg, pc_next;
    logic [phdf_pkg::SLOT_W-1:0] scan_reg, scan_next;
    logic [phdf_pkg::CNT_W-1:0]  cnt_reg, cnt_next;

    // Output register.
    logic                          out_valid_reg, out_valid_next;
    logic [phdf_pkg::KIND_W-1:0]   kind_reg, kind_next;
    logic [phdf_pkg::INDEX_W-1:0]  index_reg, index_next;
    logic [phdf_pkg::ADDR_W-1:0]   rtarget_reg, rtarget_next;
    logic [phdf_pkg::PORT_W-1:0]   rport_reg, rport_next;
    logic [phdf_pkg::BUS_W-1:0]    rbus_reg, rbus_next;
    logic                          last_reg, last_next;

    phdf_pkg::ucw_t              cw;
    phdf_pkg::hook_t             scan_hook;
    logic                        in_accept;
    logic                        ping_hit;
    logic                        match_hit;
    logic                        cond_ok;
    logic                        emit_want;
    logic                        out_free;
    logic                        out_load;
    logic                        step_go;
    logic                        scan_last;
    logic                        free_found;
    logic [phdf_pkg::SLOT_W-1:0] free_slot;

    assign cw        = phdf_pkg::ucode_rom(pc_reg);
    assign in_stall  = !cw.wait_in;
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    // A unicast ping addressed to this node, arriving on an existing bus.
    assign ping_hit = (dlen_reg != '0) && (fbyte_reg == ping_cmd_reg)
                   && (type_reg == ucast_type_reg)
                   && (target_reg == phdf_pkg::ADDR_W'(node_id_reg))
                   && (32'(bus_reg) < 32'(phdf_pkg::BUS_COUNT));

    // One slot is compared per scan step; a full result budget drops matches
    // so that the done result still fits.
    assign scan_hook = hook_reg[scan_reg];
    assign scan_last = (32'(scan_reg) == 32'(phdf_pkg::HOOK_SLOTS - 1));
    assign match_hit = hook_valid_reg[scan_reg]
                    && (32'(cnt_reg) < 32'(phdf_pkg::MAX_RESULTS - 1))
                    && (scan_hook.htype == phdf_pkg::TYPE_ANY
                        || scan_hook.htype == type_reg)
                    && (scan_hook.target == phdf_pkg::TARGET_ANY
                        || scan_hook.target == target_reg)
                    && (scan_hook.port == phdf_pkg::PORT_ANY
                        || scan_hook.port == port_reg)
                    && (scan_hook.first_byte == phdf_pkg::BYTE_ANY
                        || (dlen_reg != '0 && scan_hook.first_byte == fbyte_reg));

    // Lowest free slot for an attach.
    always_comb
    begin
        free_found = 1'b0;
        free_slot  = '0;
        for (int i = phdf_pkg::HOOK_SLOTS - 1; i >= 0; i--)
        begin
            if (!hook_valid_reg[i])
            begin
                free_found = 1'b1;
                free_slot  = phdf_pkg::SLOT_W'(i);
            end
        end
    end

    always_comb
    begin
        case (cw.cond)
            phdf_pkg::COND_ALWAYS: cond_ok = 1'b1;
            phdf_pkg::COND_PING:   cond_ok = ping_hit;
            phdf_pkg::COND_MATCH:  cond_ok = match_hit;
            default:               cond_ok = 1'b0;
        endcase
    end

    // A step that has a result to give waits for room in the output register.
    assign emit_want = !cw.wait_in && cond_ok;
    assign out_load  = emit_want && out_free;
    assign step_go   = cw.wait_in ? in_accept : (!emit_want || out_free);

    always_comb
    begin
        pc_next = pc_reg;
        if (step_go)
        begin
            case (cw.seq)
                phdf_pkg::SEQ_NEXT: pc_next = phdf_pkg::STEP_W'(pc_reg + 1'b1);
                phdf_pkg::SEQ_JUMP: pc_next = cw.jump;
                phdf_pkg::SEQ_FUNC:
                    pc_next = (func == phdf_pkg::FUNC_ATTACH) ? cw.jump
                            : phdf_pkg::STEP_W'(pc_reg + 1'b1);
                phdf_pkg::SEQ_LOOP:
                    pc_next = scan_last ? phdf_pkg::STEP_W'(pc_reg + 1'b1) : pc_reg;
                default:            pc_next = phdf_pkg::STEP_IDLE;
            endcase
        end
    end

    always_comb
    begin
        scan_next = scan_reg;
        if (cw.scan_clr)
        begin
            scan_next = '0;
        end
        else if (step_go && cw.seq == phdf_pkg::SEQ_LOOP)
        begin
            scan_next = scan_last ? '0 : phdf_pkg::SLOT_W'(scan_reg + 1'b1);
        end
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (in_accept)
        begin
            cnt_next = '0;
        end
        else if (out_load)
        begin
            cnt_next = phdf_pkg::CNT_W'(cnt_reg + 1'b1);
        end
    end

    // Result assembly.
    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        kind_next      = kind_reg;
        index_next     = index_reg;
        rtarget_next   = rtarget_reg;
        rport_next     = rport_reg;
        rbus_next      = rbus_reg;
        last_next      = last_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            last_next      = cw.last;
            kind_next      = cw.kind;
            index_next     = '0;
            rtarget_next   = '0;
            rport_next     = '0;
            rbus_next      = '0;
            if (cw.attach)
            begin
                kind_next  = free_found ? phdf_pkg::KIND_ATTACH_OK : phdf_pkg::KIND_FULL;
                index_next = free_found ? phdf_pkg::INDEX_W'(free_slot) : '0;
            end
            case (cw.cond)
                phdf_pkg::COND_MATCH:
                begin
                    index_next = phdf_pkg::INDEX_W'(scan_reg);
                end
                phdf_pkg::COND_PING:
                begin
                    rtarget_next = source_reg;
                    rport_next   = port_reg;
                    rbus_next    = bus_reg;
                end
                default:
                begin
                    index_next = index_next;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_id_reg    <= '0;
            ping_cmd_reg   <= '0;
            ucast_type_reg <= '0;
            hook_valid_reg <= '0;
            pc_reg         <= phdf_pkg::STEP_IDLE;
            scan_reg       <= '0;
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    phdf_pkg::CFG_NODE_ID:      node_id_reg    <= cfg_data;
                    phdf_pkg::CFG_PING_COMMAND: ping_cmd_reg   <= cfg_data[phdf_pkg::BYTE_W-1:0];
                    phdf_pkg::CFG_UNICAST_TYPE: ucast_type_reg <= cfg_data[phdf_pkg::TYPE_W-1:0];
                    default:                    node_id_reg    <= node_id_reg;
                endcase
            end
            if (out_load && cw.attach && free_found)
            begin
                hook_valid_reg[free_slot] <= 1'b1;
            end
            pc_reg        <= pc_next;
            scan_reg      <= scan_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            type_reg   <= pkt_type;
            target_reg <= target;
            source_reg <= source;
            port_reg   <= port;
            dlen_reg   <= data_length;
            fbyte_reg  <= first_byte;
            bus_reg    <= bus_index;
        end
        if (out_load && cw.attach && free_found)
        begin
            hook_reg[free_slot] <= '{htype: type_reg, target: target_reg,
                                     port: port_reg, first_byte: fbyte_reg};
        end
        kind_reg    <= kind_next;
        index_reg   <= index_next;
        rtarget_reg <= rtarget_next;
        rport_reg   <= rport_next;
        rbus_reg    <= rbus_next;
        last_reg    <= last_next;
    end

    assign out_valid    = out_valid_reg;
    assign kind         = kind_reg;
    assign hook_index   = index_reg;
    assign reply_target = rtarget_reg;
    assign reply_port   = rport_reg;
    assign reply_bus    = rbus_reg;
    assign last         = last_reg;

    // An accepted attach word goes straight to the attach step.
    a_attach_branch: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && func == phdf_pkg::FUNC_ATTACH |=> pc_reg == phdf_pkg::STEP_ATTACH)
        else $error("attach word did not branch to the attach step");

    // Attach results always close their word.
    a_attach_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (kind_reg == phdf_pkg::KIND_ATTACH_OK
                          || kind_reg == phdf_pkg::KIND_FULL) |-> last_reg)
        else $error("attach result without last");

    // The number of results given for one packet stays within the budget.
    a_result_budget: assert property (@(posedge clk) disable iff (!rst_n)
        32'(cnt_reg) <= 32'(phdf_pkg::MAX_RESULTS))
        else $error("result count exceeds the budget");

    // A new word is taken only after the previous word's final result was loaded.
    a_accept_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && $past(out_load) |-> $past(cw.last))
        else $error("input taken before the final result was issued");

endmodule

`default_nettype wire
